/* hdl/bbwt_pkg.sv */
// ----------------------------------------------------------------------------
// bbwt_pkg
// Shared widths, limits and codes of the bridge balance wiper tracker.
// ----------------------------------------------------------------------------
package bbwt_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int NCH_W        = $clog2(MAX_CHANNELS + 1);
  localparam int WIPER_LEVELS = 1024;
  localparam int WIPER_W      = 10;
  localparam int CNT_W        = 11;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_CH_W     = 4;
  localparam int TRIG_W       = 10;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CHANNELS   = 3'd0,
    REG_HIGH_THRESHOLD = 3'd1,
    REG_LOW_THRESHOLD  = 3'd2,
    REG_TRIGGER_COUNT  = 3'd3,
    REG_WIPER_STEP     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MOVE_NONE  = 2'd0,
    MOVE_RAISE = 2'd1,
    MOVE_LOWER = 2'd2
  } move_t;

  localparam logic [NUM_CH_W-1:0]         RST_NUM_CHANNELS   = 4'd2;
  localparam logic signed [SAMPLE_W-1:0]  RST_HIGH_THRESHOLD = 16'sd4000;
  localparam logic signed [SAMPLE_W-1:0]  RST_LOW_THRESHOLD  = -16'sd100;
  localparam logic [TRIG_W-1:0]           RST_TRIGGER_COUNT  = 10'd3;
  localparam logic [WIPER_W-1:0]          RST_WIPER_STEP     = 10'd5;

endpackage

/* hdl/bbwt_sample_if.sv */
// ----------------------------------------------------------------------------
// bbwt_sample_if
// Input channel: ADC samples and wiper presets.
// ----------------------------------------------------------------------------
interface bbwt_sample_if;
  import bbwt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;
  logic [CH_W-1:0]            preset_channel;
  logic [WIPER_W-1:0]         preset_wiper;

  modport source (output valid, mode, sample, frame_end, preset_channel, preset_wiper,
                  input ready);
  modport sink   (input valid, mode, sample, frame_end, preset_channel, preset_wiper,
                  output ready);
endinterface

/* hdl/bbwt_report_if.sv */
// ----------------------------------------------------------------------------
// bbwt_report_if
// Output channel: per-channel wiper reports at frame end.
// ----------------------------------------------------------------------------
interface bbwt_report_if;
  import bbwt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_channel;
  logic [WIPER_W-1:0] wiper_position;
  logic [1:0]         wiper_move;
  logic               last_report;

  modport source (output valid, out_channel, wiper_position, wiper_move, last_report,
                  input ready);
  modport sink   (input valid, out_channel, wiper_position, wiper_move, last_report,
                  output ready);
endinterface

/* hdl/bbwt_cfg_if.sv */
// ----------------------------------------------------------------------------
// bbwt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bbwt_cfg_if;
  import bbwt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bridge_balance_wiper_tracker.sv */
// ----------------------------------------------------------------------------
// bridge_balance_wiper_tracker
// Per-channel balance counters and wiper positions kept in two small RAMs.
// A sample item is taken in idle; its counter is written back in the next
// cycle (update state), and only then does the block take another item.
// At frame end each channel passes a RAM read state and a decide state that
// registers its report and writes its wiper back; a stall holds that state.
// Reset loads the register defaults, returns to idle and clears the phase and
// RAM valid bits, so counters and wipers read as zero without a clearing pass.
// ----------------------------------------------------------------------------
module bridge_balance_wiper_tracker (
  input  logic            clk,
  input  logic            rst,
  bbwt_sample_if.sink     samp,
  bbwt_report_if.source   rpt,
  bbwt_cfg_if.sink        cfg
);
  import bbwt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_RD   = 4'b0100,
    S_CALC = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [NUM_CH_W-1:0]        num_channels;
  logic signed [SAMPLE_W-1:0] high_threshold;
  logic signed [SAMPLE_W-1:0] low_threshold;
  logic [TRIG_W-1:0]          trigger_count;
  logic [WIPER_W-1:0]         wiper_step;

  // memories and their valid bits
  logic signed [CNT_W-1:0] cnt_mem [MAX_CHANNELS];
  logic [WIPER_W-1:0]      wip_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] cnt_vld;
  logic [MAX_CHANNELS-1:0] wip_vld;
  logic signed [CNT_W-1:0] cnt_rd;
  logic [WIPER_W-1:0]      wip_rd;
  logic [CH_W-1:0]         cnt_addr;

  logic [CH_W-1:0]            phase;
  logic [CH_W-1:0]            ch;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       frame_end_q;
  logic [CH_W-1:0]            idx;

  logic [NCH_W-1:0]        n_act;
  logic [CH_W-1:0]         ch_sel;
  logic [NCH_W-1:0]        ch_inc;
  logic                    samp_fire;
  logic                    rpt_load;
  logic signed [CNT_W-1:0] cnt_cur;
  logic signed [CNT_W-1:0] cnt_next;
  logic signed [CNT_W-1:0] rep_cnt;
  logic [WIPER_W-1:0]      rep_w;
  logic [WIPER_W:0]        w_sum;
  logic [WIPER_W-1:0]      w_next;
  move_t                   move_next;
  logic                    last_next;
  logic signed [CNT_W:0]   trig_pos;
  logic signed [CNT_W:0]   trig_neg;
  logic signed [CNT_W:0]   rep_cnt_x;

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels   <= RST_NUM_CHANNELS;
      high_threshold <= RST_HIGH_THRESHOLD;
      low_threshold  <= RST_LOW_THRESHOLD;
      trigger_count  <= RST_TRIGGER_COUNT;
      wiper_step     <= RST_WIPER_STEP;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_NUM_CHANNELS:   num_channels   <= cfg.data[NUM_CH_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold <= $signed(cfg.data[SAMPLE_W-1:0]);
        REG_LOW_THRESHOLD:  low_threshold  <= $signed(cfg.data[SAMPLE_W-1:0]);
        REG_TRIGGER_COUNT:  trigger_count  <= cfg.data[TRIG_W-1:0];
        REG_WIPER_STEP:     wiper_step     <= cfg.data[WIPER_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the channel count to 1..MAX_CHANNELS
  always_comb begin
    if (num_channels == '0) begin
      n_act = NCH_W'(1);
    end else if (NCH_W'(num_channels) > NCH_W'(MAX_CHANNELS)) begin
      n_act = NCH_W'(MAX_CHANNELS);
    end else begin
      n_act = NCH_W'(num_channels);
    end
  end

  // restart at channel 0 if the phase is at or beyond the count
  assign ch_sel = (NCH_W'(phase) >= n_act) ? '0 : phase;
  assign ch_inc = NCH_W'(ch) + NCH_W'(1);

  // ---------------- handshakes ----------------
  assign samp.ready = (state == S_IDLE);
  assign samp_fire  = samp.valid && samp.ready;
  assign rpt_load   = (state == S_CALC) && (!rpt.valid || rpt.ready);

  // ---------------- memory reads ----------------
  assign cnt_addr = (state == S_IDLE) ? ch_sel : idx;

  always_ff @(posedge clk) begin
    cnt_rd <= cnt_mem[cnt_addr];
    wip_rd <= wip_mem[idx];
  end

  // ---------------- counter update ----------------
  assign cnt_cur = cnt_vld[ch] ? cnt_rd : '0;

  always_comb begin
    cnt_next = cnt_cur;
    if (sample_q > high_threshold) begin
      if (cnt_cur != CNT_MAX) cnt_next = cnt_cur + CNT_W'(1);
    end else if (sample_q < low_threshold) begin
      if (cnt_cur != CNT_MIN) cnt_next = cnt_cur - CNT_W'(1);
    end else if (cnt_cur > 0) begin
      cnt_next = cnt_cur - CNT_W'(1);
    end else if (cnt_cur < 0) begin
      cnt_next = cnt_cur + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      cnt_mem[ch] <= cnt_next;
    end
  end

  // ---------------- frame decision ----------------
  assign rep_cnt   = cnt_vld[idx] ? cnt_rd : '0;
  assign rep_w     = wip_vld[idx] ? wip_rd : '0;
  assign rep_cnt_x = (CNT_W + 1)'(rep_cnt);
  assign trig_pos  = $signed({{(CNT_W + 1 - TRIG_W){1'b0}}, trigger_count});
  assign trig_neg  = -trig_pos;
  assign w_sum     = {1'b0, rep_w} + {1'b0, wiper_step};
  assign last_next = (NCH_W'(idx) + NCH_W'(1)) == n_act;

  always_comb begin
    move_next = MOVE_NONE;
    w_next    = rep_w;
    if (rep_cnt_x > trig_pos) begin
      move_next = MOVE_RAISE;
      if (w_sum < (WIPER_W + 1)'(WIPER_LEVELS)) w_next = w_sum[WIPER_W-1:0];
    end else if (rep_cnt_x < trig_neg) begin
      move_next = MOVE_LOWER;
      if (rep_w >= wiper_step) w_next = rep_w - wiper_step;
    end
  end

  // wiper RAM: preset in idle, decision write-back while reporting
  always_ff @(posedge clk) begin
    if (samp_fire && samp.mode) begin
      wip_mem[samp.preset_channel] <= samp.preset_wiper;
    end else if (rpt_load) begin
      wip_mem[idx] <= w_next;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= '0;
      idx     <= '0;
      cnt_vld <= '0;
      wip_vld <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (samp_fire) begin
            if (samp.mode) begin
              wip_vld[samp.preset_channel] <= 1'b1;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          cnt_vld[ch] <= 1'b1;
          phase       <= (ch_inc >= n_act) ? '0 : ch_inc[CH_W-1:0];
          idx         <= '0;
          state       <= frame_end_q ? S_RD : S_IDLE;
        end
        S_RD: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (rpt_load) begin
            wip_vld[idx] <= 1'b1;
            if (last_next) begin
              // frame done: drop all counters, restart phase
              cnt_vld <= '0;
              phase   <= '0;
              state   <= S_IDLE;
            end else begin
              idx   <= idx + CH_W'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // hold the sample item for the update cycle
  always_ff @(posedge clk) begin
    if (samp_fire) begin
      ch          <= ch_sel;
      sample_q    <= samp.sample;
      frame_end_q <= samp.frame_end;
    end
  end

  // ---------------- report register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt.valid <= 1'b0;
    end else if (rpt_load) begin
      rpt.valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_load) begin
      rpt.out_channel    <= idx;
      rpt.wiper_position <= w_next;
      rpt.wiper_move     <= move_next;
      rpt.last_report    <= last_next;
    end
  end

endmodule

/* hdl/bbwt_checker.sv */
// ----------------------------------------------------------------------------
// bbwt_port_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bbwt_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bbwt_pkg::CH_W-1:0]    out_channel,
  input logic [bbwt_pkg::WIPER_W-1:0] wiper_position,
  input logic [1:0]                  wiper_move,
  input logic                        last_report
);
  import bbwt_pkg::*;

  // a stalled report holds its payload
  a_rpt_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
      $stable(wiper_position) && $stable(wiper_move) && $stable(last_report))
    else $error("report changed while stalled");

  // no report right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report valid after reset");

  // inputs wait while a frame report is still being walked
  a_walk_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_report |-> !in_ready)
    else $error("input accepted during frame report");

  // move code is one of none, raise, lower
  a_move_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wiper_move == MOVE_NONE || wiper_move == MOVE_RAISE ||
                   wiper_move == MOVE_LOWER))
    else $error("bad wiper move code");

  // a non-last report is followed by the next channel, at once or after one gap
  a_next_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_report |=>
      (out_valid && out_channel == $past(out_channel) + CH_W'(1)) or
      (!out_valid ##1 (out_valid && out_channel == $past(out_channel, 2) + CH_W'(1))))
    else $error("report channel order broken");

endmodule

bind bridge_balance_wiper_tracker bbwt_port_checker u_bbwt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (samp.ready),
  .out_valid      (rpt.valid),
  .out_ready      (rpt.ready),
  .out_channel    (rpt.out_channel),
  .wiper_position (rpt.wiper_position),
  .wiper_move     (rpt.wiper_move),
  .last_report    (rpt.last_report)
);

/* tb/bbwt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbwt_checker
// Passive scoreboard for the bridge balance wiper tracker: follows every
// register write and accepted item, keeps its own copy of the counters,
// phase and wipers, and compares each accepted report with the oldest one due.
// ----------------------------------------------------------------------------
module bbwt_checker (
  input  logic   clk,
  input  logic   rst,
  bbwt_sample_if samp,
  bbwt_report_if rpt,
  bbwt_cfg_if    cfg,
  output int     errors,
  output int     pending,
  output int     reports_seen
);
  import bbwt_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [WIPER_W-1:0] pos;
    move_t              move;
    logic               last;
  } wiper_report_t;

  logic [NUM_CH_W-1:0]        num_ch;
  logic signed [SAMPLE_W-1:0] hi_thr;
  logic signed [SAMPLE_W-1:0] lo_thr;
  logic [TRIG_W-1:0]          trig;
  logic [WIPER_W-1:0]         step;
  logic [WIPER_W-1:0]         wiper [MAX_CHANNELS];
  int                         balance [MAX_CHANNELS];
  int                         phase;
  wiper_report_t              reports_due [$];
  int                         n_bad = 0;
  int                         n_rpt = 0;

  task automatic note_mismatch(input string what);
    n_bad++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic clear_tracker();
    num_ch = RST_NUM_CHANNELS;
    hi_thr = RST_HIGH_THRESHOLD;
    lo_thr = RST_LOW_THRESHOLD;
    trig   = RST_TRIGGER_COUNT;
    step   = RST_WIPER_STEP;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      wiper[i]   = '0;
      balance[i] = 0;
    end
    phase = 0;
    reports_due.delete();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_NUM_CHANNELS:   num_ch = d[NUM_CH_W-1:0];
      REG_HIGH_THRESHOLD: hi_thr = d;
      REG_LOW_THRESHOLD:  lo_thr = d;
      REG_TRIGGER_COUNT:  trig   = d[TRIG_W-1:0];
      REG_WIPER_STEP:     step   = d[WIPER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic track_item(input logic md, input logic signed [SAMPLE_W-1:0] smp,
                            input logic fe, input logic [CH_W-1:0] pch,
                            input logic [WIPER_W-1:0] pw);
    int    n;
    int    ch;
    int    c;
    int    w;
    move_t mv;
    // preset channel is 3 bits wide, so it is always in range here
    if (md) begin
      wiper[pch] = pw;
      return;
    end
    n  = (num_ch == 0) ? 1 : (int'(num_ch) > MAX_CHANNELS) ? MAX_CHANNELS : int'(num_ch);
    // restart at channel 0 when the count shrank to the phase or below it
    ch = (phase >= n) ? 0 : phase;
    c  = balance[ch];
    if (smp > hi_thr) begin
      if (c < int'(CNT_MAX)) c++;
    end else if (smp < lo_thr) begin
      if (c > int'(CNT_MIN)) c--;
    end else if (c > 0) begin
      c--;
    end else if (c < 0) begin
      c++;
    end
    balance[ch] = c;
    phase = (ch + 1 >= n) ? 0 : ch + 1;
    if (!fe) return;

    for (int i = 0; i < n; i++) begin
      w  = wiper[i];
      mv = MOVE_NONE;
      // move is flagged even when the limit blocks the step
      if (balance[i] > int'(trig)) begin
        mv = MOVE_RAISE;
        if (w + int'(step) < WIPER_LEVELS) w = w + int'(step);
      end else if (balance[i] < -int'(trig)) begin
        mv = MOVE_LOWER;
        if (w >= int'(step)) w = w - int'(step);
      end
      wiper[i] = w[WIPER_W-1:0];
      reports_due.push_back('{ch: i[CH_W-1:0], pos: w[WIPER_W-1:0], move: mv,
                              last: (i == n - 1)});
    end
    for (int i = 0; i < MAX_CHANNELS; i++) balance[i] = 0;
    phase = 0;
  endtask

  task automatic check_report();
    wiper_report_t want;
    n_rpt++;
    if (reports_due.size() == 0) begin
      note_mismatch($sformatf("report for channel %0d with none due", rpt.out_channel));
      return;
    end
    want = reports_due.pop_front();
    if (rpt.out_channel !== want.ch)
      note_mismatch($sformatf("out_channel %0d, want %0d", rpt.out_channel, want.ch));
    if (rpt.wiper_position !== want.pos)
      note_mismatch($sformatf("ch %0d wiper_position %0d, want %0d",
                              want.ch, rpt.wiper_position, want.pos));
    if (rpt.wiper_move !== want.move)
      note_mismatch($sformatf("ch %0d wiper_move %0d, want %s",
                              want.ch, rpt.wiper_move, want.move.name()));
    if (rpt.last_report !== want.last)
      note_mismatch($sformatf("ch %0d last_report %0b, want %0b",
                              want.ch, rpt.last_report, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tracker();
    end else begin
      if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
      if (samp.valid && samp.ready)
        track_item(samp.mode, samp.sample, samp.frame_end, samp.preset_channel,
                   samp.preset_wiper);
      if (rpt.valid && rpt.ready) check_report();
    end
    pending      <= reports_due.size();
    errors       <= n_bad;
    reports_seen <= n_rpt;
  end

  final begin
    if (reports_due.size() != 0)
      $display("%0d reports still due at end of run", reports_due.size());
  end

endmodule

/* tb/tb_bridge_balance_wiper_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bridge_balance_wiper_tracker
// Drives samples, presets and register writes into the tracker with random
// gaps and report stalls; the checker scores every report.
// ----------------------------------------------------------------------------
module tb_bridge_balance_wiper_tracker;
  import bbwt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 40;
  localparam int S_MAX          = (1 << (SAMPLE_W - 1)) - 1;
  localparam int S_MIN          = -(1 << (SAMPLE_W - 1));
  localparam int WIPER_TOP      = WIPER_LEVELS - 1;

  localparam int LEAN_UP   = 0;
  localparam int LEAN_DOWN = 1;
  localparam int LEAN_ANY  = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbwt_sample_if samp_if ();
  bbwt_report_if rpt_if ();
  bbwt_cfg_if    cfg_if ();

  int errors;
  int pending;
  int reports_seen;
  int n_items  = 0;
  int n_writes = 0;
  int quiet    = 0;
  bit idling   = 1'b1;

  logic [NUM_CH_W-1:0]        cur_num_ch = RST_NUM_CHANNELS;
  logic signed [SAMPLE_W-1:0] cur_hi     = RST_HIGH_THRESHOLD;
  logic signed [SAMPLE_W-1:0] cur_lo     = RST_LOW_THRESHOLD;

  always #4 clk = ~clk;

  bridge_balance_wiper_tracker dut (
    .clk  (clk),
    .rst  (rst),
    .samp (samp_if),
    .rpt  (rpt_if),
    .cfg  (cfg_if)
  );

  bbwt_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .samp         (samp_if),
    .rpt          (rpt_if),
    .cfg          (cfg_if),
    .errors       (errors),
    .pending      (pending),
    .reports_seen (reports_seen)
  );

  // report side: ready bursts with occasional stalls
  initial begin
    rpt_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      rpt_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (idling && $urandom_range(0, 2) == 0) begin
        rpt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((samp_if.valid && samp_if.ready) || (rpt_if.valid && rpt_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int rand_between(input int a, input int b);
    return a + int'($urandom_range(0, b - a));
  endfunction

  function automatic int active_channels();
    if (cur_num_ch == 0) return 1;
    if (int'(cur_num_ch) > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(cur_num_ch);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int lean);
    int hi;
    int lo;
    hi = cur_hi;
    lo = cur_lo;
    if (lean == LEAN_UP && hi < S_MAX && $urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 1))
        return SAMPLE_W'(rand_between(hi + 1, (hi + 9 > S_MAX) ? S_MAX : hi + 9));
      return SAMPLE_W'(rand_between(hi + 1, S_MAX));
    end
    if (lean == LEAN_DOWN && lo > S_MIN && $urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 1))
        return SAMPLE_W'(rand_between((lo - 9 < S_MIN) ? S_MIN : lo - 9, lo - 1));
      return SAMPLE_W'(rand_between(S_MIN, lo - 1));
    end
    if (lean == LEAN_ANY && lo <= hi && $urandom_range(0, 1))
      return SAMPLE_W'(rand_between(lo, hi));
    return SAMPLE_W'($urandom);
  endfunction

  task automatic push_item(input logic md, input logic signed [SAMPLE_W-1:0] smp,
                           input logic fe, input logic [CH_W-1:0] pch,
                           input logic [WIPER_W-1:0] pw);
    if (idling && $urandom_range(0, 3) == 0) begin
      samp_if.valid  <= 1'b0;
      samp_if.sample <= SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    samp_if.valid          <= 1'b1;
    samp_if.mode           <= md;
    samp_if.sample         <= smp;
    samp_if.frame_end      <= fe;
    samp_if.preset_channel <= pch;
    samp_if.preset_wiper   <= pw;
    do @(posedge clk); while (!(samp_if.valid && samp_if.ready));
    n_items++;
  endtask

  // the unused fields carry noise in both modes
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fe);
    push_item(1'b0, smp, fe, CH_W'($urandom), WIPER_W'($urandom));
  endtask

  task automatic send_preset(input logic [CH_W-1:0] ch, input logic [WIPER_W-1:0] w);
    push_item(1'b1, SAMPLE_W'($urandom), 1'($urandom), ch, w);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    n_writes++;
    case (idx)
      REG_NUM_CHANNELS:   cur_num_ch = d[NUM_CH_W-1:0];
      REG_HIGH_THRESHOLD: cur_hi     = d;
      REG_LOW_THRESHOLD:  cur_lo     = d;
      default: ;
    endcase
  endtask

  // upper data bits of the narrow registers carry noise
  task automatic setup_regs(input int nch, input int hi, input int lo, input int trig,
                            input int step);
    cfg_write(REG_NUM_CHANNELS,   {12'($urandom), 4'(nch)});
    cfg_write(REG_HIGH_THRESHOLD, 16'(hi));
    cfg_write(REG_LOW_THRESHOLD,  16'(lo));
    cfg_write(REG_TRIGGER_COUNT,  {6'($urandom), 10'(trig)});
    cfg_write(REG_WIPER_STEP,     {6'($urandom), 10'(step)});
  endtask

  // hold until every report is in, then let the block go quiet
  task automatic settle(input int hold);
    samp_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (hold) @(posedge clk);
  endtask

  task automatic run_frames(input int items);
    int n;
    int per;
    int len;
    int sent;
    int lean [MAX_CHANNELS];
    sent = 0;
    while (sent < items) begin
      n = active_channels();
      case ($urandom_range(0, 9))
        0: begin
          send_preset(CH_W'($urandom), $urandom_range(0, 3) == 0 ?
                      WIPER_W'($urandom_range(0, 1) ? WIPER_TOP : 0) : WIPER_W'($urandom));
          sent++;
        end
        1: begin
          // broken frame: arbitrary length, may end early or not at all
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++)
            send_sample(pick_sample($urandom_range(LEAN_UP, LEAN_ANY)),
                        k == len - 1 && $urandom_range(0, 1));
          sent += len;
        end
        default: begin
          per = $urandom_range(1, 6);
          for (int c = 0; c < n; c++) lean[c] = $urandom_range(LEAN_UP, LEAN_ANY);
          for (int k = 0; k < per * n; k++)
            send_sample(pick_sample(lean[k % n]), k == per * n - 1);
          sent += per * n;
        end
      endcase
    end
  endtask

  initial begin
    int ctr;
    int hi;
    int lo;
    int swap;
    int nch;
    int trig;
    int step;

    samp_if.valid          = 1'b0;
    samp_if.mode           = 1'b0;
    samp_if.sample         = '0;
    samp_if.frame_end      = 1'b0;
    samp_if.preset_channel = '0;
    samp_if.preset_wiper   = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_NUM_CHANNELS;
    cfg_if.data            = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: wipers near both ends, full-scale samples
    send_preset(CH_W'(0), WIPER_W'(WIPER_TOP - 3));
    send_preset(CH_W'(1), WIPER_W'(2));
    send_preset(CH_W'(7), WIPER_W'(WIPER_TOP));
    for (int k = 0; k < 8; k++) send_sample(k[0] ? SAMPLE_W'(S_MIN) : SAMPLE_W'(S_MAX), k == 7);
    // samples exactly at the thresholds count as neither side
    send_sample(RST_HIGH_THRESHOLD, 1'b0);
    send_sample(RST_LOW_THRESHOLD, 1'b0);
    send_sample(SAMPLE_W'(0), 1'b1);

    // zero channels clamps to one; zero trigger, full step
    settle(SETTLE_CYCLES);
    setup_regs(0, S_MIN, S_MAX, 0, WIPER_TOP);
    send_sample(SAMPLE_W'(S_MIN), 1'b1);
    send_preset(CH_W'(0), WIPER_W'(WIPER_TOP));
    send_sample(SAMPLE_W'(S_MAX), 1'b1);

    // count above the maximum clamps to all channels; zero step
    settle(SETTLE_CYCLES);
    setup_regs(15, 100, -100, 0, 0);
    for (int k = 0; k < MAX_CHANNELS; k++)
      send_sample(k[0] ? SAMPLE_W'(-2000) : SAMPLE_W'(2000), k == MAX_CHANNELS - 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle(SETTLE_CYCLES);
      if (p == RANDOM_PHASES - 1) idling = 1'b0;
      ctr = rand_between(S_MIN, S_MAX);
      hi  = ctr + rand_between(0, 3000);
      lo  = ctr - rand_between(0, 3000);
      if (hi > S_MAX) hi = S_MAX;
      if (lo < S_MIN) lo = S_MIN;
      if (p == 2) begin
        hi = S_MAX;
        lo = S_MIN;
      end
      if (p == 3) begin
        swap = hi;
        hi   = lo;
        lo   = swap;
      end
      nch  = (p == 0) ? 1 : (p == 1) ? MAX_CHANNELS : rand_between(0, 15);
      trig = (p == 4) ? 0 : (p == 5) ? 1023 : rand_between(0, 6);
      step = (p == 1) ? WIPER_TOP : (p == 6) ? 0 : rand_between(1, 600);
      setup_regs(nch, hi, lo, trig, step);
      // unmapped register index, ignored by the block
      cfg_write(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
      // shrink the count mid-frame on some phases to test the phase restart
      if (p == 4 || p == 6) begin
        for (int k = 0; k < 3; k++) send_sample(pick_sample(LEAN_ANY), 1'b0);
        settle(SETTLE_CYCLES);
        cfg_write(REG_NUM_CHANNELS, CFG_DATA_W'(rand_between(1, 2)));
      end
      run_frames(PHASE_ITEMS);
    end

    settle(20);
    $display("covered %0d items (full-scale, clamping, %0d random phases), %0d writes",
             n_items, RANDOM_PHASES, n_writes);
    $display("scored %0d wiper reports", reports_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bbwt_pkg.sv
hdl/bbwt_sample_if.sv
hdl/bbwt_report_if.sv
hdl/bbwt_cfg_if.sv
hdl/bridge_balance_wiper_tracker.sv
hdl/bbwt_checker.sv
tb/bbwt_checker.sv
tb/tb_bridge_balance_wiper_tracker.sv
